@@ rtl/irs_pkg.sv @@
// Shared types and constants for the IR reflection sensor datapath.
// Used by irs_exp and ir_reflection_sensor_model; no dependencies.
package irs_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SCALE = 3'd0,
    CFG_CUTOFF     = 3'd1,
    CFG_DIST_OFFS  = 3'd2,
    CFG_REF_DIST   = 3'd3,
    CFG_RED_ONLY   = 3'd4,
    CFG_SIG_WIDTH  = 3'd5,
    CFG_SIG_CENTER = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] FullScaleRst = 16'd4505;
  localparam logic [15:0] SigWidthRst  = 16'd7209;
  localparam logic [15:0] SigCenterRst = 16'd28836;

  // 0.8 and 0.2 in Q0.16
  localparam logic [15:0] RedGain = 16'd52429;
  localparam logic [15:0] RedBias = 16'd13107;

  // floor(2^18/3): reciprocal for the RGB mean
  localparam logic [16:0] MeanRecip = 17'd87381;
  localparam int unsigned MeanShift = 18;

  localparam int unsigned TaylorTerms = 12;
  localparam int unsigned SquareSteps = 6;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [15:0] nmag;
  } geom_t;

endpackage

@@ rtl/irs_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Requires dividend < divisor << QW. Uses no package items.
module irs_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = DW + VW + QW;

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [VW-1:0] dvs_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [CW-1:0] trial;
    logic          fits;

    if (j == 0) begin : g_first
      assign rem_in  = dividend_i;
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign dvs_in  = dvs_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign trial = CW'(dvs_in) << (QW - 1 - j);
    assign fits  = CW'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= fits ? DW'(CW'(rem_in) - trial) : rem_in;
      quo_q[j]  <= quo_in | (fits ? (QW'(1) << (QW - 1 - j)) : QW'(0));
      dvs_q[j]  <= dvs_in;
      side_q[j] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

@@ rtl/irs_term.sv @@
// One Taylor term of exp(-u): multiply by u, divide by the constant N, accumulate.
// Division by N (for N > 1) uses a reciprocal multiply and one correction; no package items.
module irs_term #(
  parameter int unsigned N  = 1,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   u_i,
  input  logic [33:0]   sum_i,
  input  logic [32:0]   term_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   u_o,
  output logic [33:0]   sum_o,
  output logic [32:0]   term_o,
  output logic [SW-1:0] side_o
);

  logic [64:0]   prod_a;
  logic          vld_a_q;
  logic [32:0]   p_a_q;
  logic [31:0]   u_a_q;
  logic [33:0]   sum_a_q;
  logic [SW-1:0] side_a_q;

  logic          vld_c_q;
  logic [31:0]   u_c_q;
  logic [33:0]   sum_c_q;
  logic [32:0]   term_c_q;
  logic [SW-1:0] side_c_q;

  assign prod_a = {32'd0, term_i} * {33'd0, u_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_a_q    <= prod_a[64:32];
    u_a_q    <= u_i;
    sum_a_q  <= sum_i;
    side_a_q <= side_i;
  end

  if (N == 1) begin : g_unit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_c_q <= 1'b0;
      end else begin
        vld_c_q <= vld_a_q;
      end
    end

    always_ff @(posedge clk_i) begin
      u_c_q    <= u_a_q;
      sum_c_q  <= sum_a_q - 34'(p_a_q);
      term_c_q <= p_a_q;
      side_c_q <= side_a_q;
    end
  end else begin : g_recip
    localparam logic [32:0] Recip = 33'((64'd1 << 33) / N);

    logic          vld_b_q;
    logic [65:0]   mq_b_q;
    logic [32:0]   p_b_q;
    logic [31:0]   u_b_q;
    logic [33:0]   sum_b_q;
    logic [SW-1:0] side_b_q;
    logic [32:0]   q_est;
    logic [32:0]   rem;
    logic [32:0]   q_fix;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_b_q <= 1'b0;
        vld_c_q <= 1'b0;
      end else begin
        vld_b_q <= vld_a_q;
        vld_c_q <= vld_b_q;
      end
    end

    always_ff @(posedge clk_i) begin
      mq_b_q   <= 66'(p_a_q) * 66'(Recip);
      p_b_q    <= p_a_q;
      u_b_q    <= u_a_q;
      sum_b_q  <= sum_a_q;
      side_b_q <= side_a_q;
    end

    // estimate is low by at most one
    assign q_est = mq_b_q[65:33];
    assign rem   = p_b_q - 33'(q_est * 33'(N));
    assign q_fix = (rem >= 33'(N)) ? q_est + 33'd1 : q_est;

    always_ff @(posedge clk_i) begin
      u_c_q    <= u_b_q;
      sum_c_q  <= (N % 2 == 1) ? sum_b_q - 34'(q_fix) : sum_b_q + 34'(q_fix);
      term_c_q <= q_fix;
      side_c_q <= side_b_q;
    end
  end

  assign valid_o = vld_c_q;
  assign u_o     = u_c_q;
  assign sum_o   = sum_c_q;
  assign term_o  = term_c_q;
  assign side_o  = side_c_q;

endmodule

@@ rtl/irs_exp.sv @@
// exp(-x) pipeline: x/64 series over irs_term stages, cap, then six squarings.
// Depends on irs_pkg (default fraction width, term and square counts) and irs_term.
module irs_exp #(
  parameter int unsigned FRAC_BITS = irs_pkg::FracBitsDef,
  parameter int unsigned SW        = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [FRAC_BITS+5:0] x_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [31:0]          e_o,
  output logic [SW-1:0]        side_o
);

  localparam int unsigned NT = irs_pkg::TaylorTerms;
  localparam int unsigned NS = irs_pkg::SquareSteps;

  logic [37:0]   xs;
  logic          vld0_q;
  logic [31:0]   u0_q;
  logic [SW-1:0] side0_q;

  logic          vld_w  [NT+1];
  logic [31:0]   u_w    [NT+1];
  logic [33:0]   sum_w  [NT+1];
  logic [32:0]   term_w [NT+1];
  logic [SW-1:0] side_w [NT+1];

  logic          cap_vld_q;
  logic [31:0]   cap_q;
  logic [SW-1:0] cap_side_q;

  logic          sq_vld_q  [NS];
  logic [31:0]   sq_q      [NS];
  logic [SW-1:0] sq_side_q [NS];

  // u = x/64 in Q0.32
  assign xs = 38'(x_i) << (32 - FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    u0_q    <= xs[37:6];
    side0_q <= side_i;
  end

  assign vld_w[0]  = vld0_q;
  assign u_w[0]    = u0_q;
  assign sum_w[0]  = 34'd1 << 32;
  assign term_w[0] = 33'd1 << 32;
  assign side_w[0] = side0_q;

  for (genvar n = 0; n < NT; n++) begin : g_term
    irs_term #(
      .N  (n + 1),
      .SW (SW)
    ) u_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[n]),
      .u_i     (u_w[n]),
      .sum_i   (sum_w[n]),
      .term_i  (term_w[n]),
      .side_i  (side_w[n]),
      .valid_o (vld_w[n+1]),
      .u_o     (u_w[n+1]),
      .sum_o   (sum_w[n+1]),
      .term_o  (term_w[n+1]),
      .side_o  (side_w[n+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_vld_q <= 1'b0;
    end else begin
      cap_vld_q <= vld_w[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q      <= (sum_w[NT] > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum_w[NT][31:0];
    cap_side_q <= side_w[NT];
  end

  for (genvar s = 0; s < NS; s++) begin : g_square
    logic          vld_in;
    logic [31:0]   e_in;
    logic [SW-1:0] side_in;
    logic [63:0]   sq;

    if (s == 0) begin : g_first
      assign vld_in  = cap_vld_q;
      assign e_in    = cap_q;
      assign side_in = cap_side_q;
    end else begin : g_next
      assign vld_in  = sq_vld_q[s-1];
      assign e_in    = sq_q[s-1];
      assign side_in = sq_side_q[s-1];
    end

    assign sq = 64'(e_in) * 64'(e_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s] <= 1'b0;
      end else begin
        sq_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[s]      <= sq[63:32];
      sq_side_q[s] <= side_in;
    end
  end

  assign valid_o = sq_vld_q[NS-1];
  assign e_o     = sq_q[NS-1];
  assign side_o  = sq_side_q[NS-1];

endmodule

@@ rtl/ir_reflection_sensor_model.sv @@
// Top level of the IR reflection sensor datapath: config registers and pipeline glue.
// Depends on irs_pkg, irs_div and irs_exp.
//
//   channel   | handshake                      | payload
//   ----------+--------------------------------+--------------------------------------
//   detection | start_i, busy_o (always low)   | distance_i, surface_normal_i, red_i,
//             |                                | green_i, blue_i
//   result    | result_valid_o (one cycle)     | reading_o, intensity_clipped_o
//   config    | cfg_we_i                       | cfg_idx_i, cfg_data_i
//
// One word enters per cycle; the path runs through the four bit-per-stage dividers
// and the 43-stage exp series. The pipeline never stalls: the receiver takes every
// result. Reset clears the valid bits and loads the register defaults.
module ir_reflection_sensor_model #(
  parameter int unsigned FRAC_BITS = irs_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [15:0]                   distance_i,
  input  logic signed [15:0]            surface_normal_i,
  input  logic [15:0]                   red_i,
  input  logic [15:0]                   green_i,
  input  logic [15:0]                   blue_i,
  output logic                          result_valid_o,
  output logic [15:0]                   reading_o,
  output logic                          intensity_clipped_o,
  input  logic                          cfg_we_i,
  input  logic [irs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [irs_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ZW   = FRAC_BITS + 6;
  localparam int unsigned DW1  = 16 + FRAC_BITS;
  localparam int unsigned QW1  = 16 + FRAC_BITS;
  localparam int unsigned SW1  = 1 + $bits(irs_pkg::geom_t);
  localparam int unsigned DW2  = 33 + FRAC_BITS;
  localparam int unsigned QW2  = FRAC_BITS + 1;
  localparam int unsigned KW   = FRAC_BITS + 2;
  localparam int unsigned PW   = 34 + FRAC_BITS;
  localparam int unsigned CW   = 48 + FRAC_BITS;
  localparam int unsigned IW   = 16 + FRAC_BITS;
  localparam int unsigned FW   = 32 + FRAC_BITS;
  localparam int unsigned VW4  = 17 + FRAC_BITS;
  localparam logic [ZW-1:0] ZMax = ZW'(32) << FRAC_BITS;

  // configuration registers
  logic [15:0] full_scale_q, cutoff_q, dist_offs_q, ref_dist_q, sig_width_q, sig_center_q;
  logic        red_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= irs_pkg::FullScaleRst;
      cutoff_q     <= '0;
      dist_offs_q  <= '0;
      ref_dist_q   <= '0;
      red_only_q   <= 1'b0;
      sig_width_q  <= irs_pkg::SigWidthRst;
      sig_center_q <= irs_pkg::SigCenterRst;
    end else if (cfg_we_i) begin
      case (irs_pkg::cfg_idx_e'(cfg_idx_i))
        irs_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        irs_pkg::CFG_CUTOFF:     cutoff_q     <= cfg_data_i;
        irs_pkg::CFG_DIST_OFFS:  dist_offs_q  <= cfg_data_i;
        irs_pkg::CFG_REF_DIST:   ref_dist_q   <= cfg_data_i;
        irs_pkg::CFG_RED_ONLY:   red_only_q   <= cfg_data_i[0];
        irs_pkg::CFG_SIG_WIDTH:  sig_width_q  <= cfg_data_i;
        irs_pkg::CFG_SIG_CENTER: sig_center_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: color sums, normal magnitude, distance differences
  logic [15:0] nbits;
  logic [17:0] rgb_sum;
  logic        vld1_q;
  logic [15:0] nmag1_q, dn1_q, dd1_q;
  logic [31:0] redp1_q;
  logic [17:0] sum1_q;
  logic [34:0] summ1_q;

  assign nbits   = surface_normal_i;
  assign rgb_sum = 18'(red_i) + 18'(green_i) + 18'(blue_i);

  always_ff @(posedge clk_i) begin
    nmag1_q <= nbits[15] ? 16'(~nbits + 16'd1) : nbits;
    redp1_q <= 32'(red_i) * 32'(irs_pkg::RedGain);
    sum1_q  <= rgb_sum;
    summ1_q <= 35'(rgb_sum) * 35'(irs_pkg::MeanRecip);
    dn1_q   <= (ref_dist_q >= dist_offs_q) ? ref_dist_q - dist_offs_q
                                           : dist_offs_q - ref_dist_q;
    dd1_q   <= (distance_i >= dist_offs_q) ? distance_i - dist_offs_q
                                           : dist_offs_q - distance_i;
  end

  // stage 2: color level, squared distances
  logic [16:0] mean_est;
  logic [17:0] mean_rem;
  logic [15:0] mean_v;
  logic        vld2_q;
  logic [15:0] v2_q;
  irs_pkg::geom_t geom2_q;

  assign mean_est = summ1_q[34:irs_pkg::MeanShift];
  assign mean_rem = sum1_q - 18'({mean_est, 1'b0}) - 18'(mean_est);
  assign mean_v   = (mean_rem >= 18'd3) ? 16'(mean_est + 17'd1) : 16'(mean_est);

  always_ff @(posedge clk_i) begin
    v2_q         <= red_only_q ? redp1_q[31:16] + irs_pkg::RedBias : mean_v;
    geom2_q.num  <= 32'(dn1_q) * 32'(dn1_q);
    geom2_q.den  <= 32'(dd1_q) * 32'(dd1_q);
    geom2_q.nmag <= nmag1_q;
  end

  // stage 3: distance from sigmoid center
  logic        vld3_q;
  logic        neg3_q;
  logic [15:0] mag3_q;
  irs_pkg::geom_t geom3_q;

  always_ff @(posedge clk_i) begin
    neg3_q  <= v2_q < sig_center_q;
    mag3_q  <= (v2_q < sig_center_q) ? sig_center_q - v2_q : v2_q - sig_center_q;
    geom3_q <= geom2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // z = |v - v0| / beta
  logic [15:0]    beta;
  logic           d1_vld;
  logic [QW1-1:0] d1_quot;
  logic [SW1-1:0] d1_side;

  assign beta = (sig_width_q == 16'd0) ? 16'd1 : sig_width_q;

  irs_div #(
    .DW (DW1),
    .VW (16),
    .QW (QW1),
    .SW (SW1)
  ) u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld3_q),
    .dividend_i ({mag3_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (beta),
    .side_i     ({neg3_q, geom3_q}),
    .valid_o    (d1_vld),
    .quot_o     (d1_quot),
    .side_o     (d1_side)
  );

  // stage 4: clamp z
  logic           vld4_q;
  logic [ZW-1:0]  z4_q;
  logic [SW1-1:0] side4_q;

  always_ff @(posedge clk_i) begin
    z4_q    <= (d1_quot > QW1'(ZMax)) ? ZMax : ZW'(d1_quot);
    side4_q <= d1_side;
  end

  logic           ex_vld;
  logic [31:0]    ex_e;
  logic [SW1-1:0] ex_side;
  logic           ex_neg;
  irs_pkg::geom_t ex_geom;

  irs_exp #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW1)
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld4_q),
    .x_i     (z4_q),
    .side_i  (side4_q),
    .valid_o (ex_vld),
    .e_o     (ex_e),
    .side_o  (ex_side)
  );

  assign ex_neg  = ex_side[SW1-1];
  assign ex_geom = ex_side[SW1-2:0];

  // reflectivity = 1/(1+e) or e/(1+e)
  logic [DW2-1:0] refl_num;
  logic           d2_vld;
  logic [QW2-1:0] d2_quot;
  irs_pkg::geom_t d2_geom;

  assign refl_num = ex_neg ? (DW2'(ex_e) << FRAC_BITS) : (DW2'(1) << (32 + FRAC_BITS));

  irs_div #(
    .DW (DW2),
    .VW (33),
    .QW (QW2),
    .SW ($bits(irs_pkg::geom_t))
  ) u_div_refl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (ex_vld),
    .dividend_i (refl_num),
    .divisor_i  ({1'b1, ex_e}),
    .side_i     (ex_geom),
    .valid_o    (d2_vld),
    .quot_o     (d2_quot),
    .side_o     (d2_geom)
  );

  // stage 6: k = |normal| * reflectivity
  logic [16+FRAC_BITS:0] nk;
  logic           vld6_q;
  logic [KW-1:0]  k6_q;
  logic [31:0]    num6_q, den6_q;

  assign nk = (17 + FRAC_BITS)'(d2_geom.nmag) * (17 + FRAC_BITS)'(d2_quot);

  always_ff @(posedge clk_i) begin
    k6_q   <= nk[FRAC_BITS+15:14];
    num6_q <= d2_geom.num;
    den6_q <= d2_geom.den;
  end

  // stage 7: numerator product
  logic          vld7_q;
  logic [PW-1:0] prod7_q;
  logic [31:0]   den7_q;

  always_ff @(posedge clk_i) begin
    prod7_q <= PW'(num6_q) * PW'(k6_q);
    den7_q  <= den6_q;
  end

  // stage 8: saturation check ahead of the divide
  logic          vld8_q;
  logic [PW-1:0] prod8_q;
  logic [31:0]   den8_q;
  logic          clip8_q;

  always_ff @(posedge clk_i) begin
    prod8_q <= prod7_q;
    den8_q  <= den7_q;
    clip8_q <= (den7_q == 32'd0) || (CW'(prod7_q) >= (CW'(den7_q) << IW));
  end

  logic          d3_vld;
  logic [IW-1:0] d3_quot;
  logic          d3_clip;

  irs_div #(
    .DW (PW),
    .VW (32),
    .QW (IW),
    .SW (1)
  ) u_div_int (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld8_q),
    .dividend_i (prod8_q),
    .divisor_i  (den8_q),
    .side_i     (clip8_q),
    .valid_o    (d3_vld),
    .quot_o     (d3_quot),
    .side_o     (d3_clip)
  );

  // stage 9: saturate intensity
  logic          vld9_q;
  logic [IW-1:0] int9_q;
  logic          clip9_q;

  always_ff @(posedge clk_i) begin
    int9_q  <= d3_clip ? {IW{1'b1}} : d3_quot;
    clip9_q <= d3_clip;
  end

  // stage 10: full_scale * I and I + 1
  logic           vld10_q;
  logic [FW-1:0]  fsi10_q;
  logic [VW4-1:0] dvs10_q;
  logic           zero10_q, clip10_q;

  always_ff @(posedge clk_i) begin
    fsi10_q  <= FW'(full_scale_q) * FW'(int9_q);
    dvs10_q  <= VW4'(int9_q) + (VW4'(1) << FRAC_BITS);
    zero10_q <= int9_q == '0;
    clip10_q <= clip9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q  <= 1'b0;
      vld6_q  <= 1'b0;
      vld7_q  <= 1'b0;
      vld8_q  <= 1'b0;
      vld9_q  <= 1'b0;
      vld10_q <= 1'b0;
    end else begin
      vld4_q  <= d1_vld;
      vld6_q  <= d2_vld;
      vld7_q  <= vld6_q;
      vld8_q  <= vld7_q;
      vld9_q  <= d3_vld;
      vld10_q <= vld9_q;
    end
  end

  logic        d4_vld;
  logic [15:0] d4_quot;
  logic [1:0]  d4_side;

  irs_div #(
    .DW (FW),
    .VW (VW4),
    .QW (16),
    .SW (2)
  ) u_div_rd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld10_q),
    .dividend_i (fsi10_q),
    .divisor_i  (dvs10_q),
    .side_i     ({clip10_q, zero10_q}),
    .valid_o    (d4_vld),
    .quot_o     (d4_quot),
    .side_o     (d4_side)
  );

  // output register: zero the reading for zero intensity or a reading under the cutoff
  logic        out_vld_q;
  logic [15:0] reading_q;
  logic        clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= d4_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    reading_q <= (d4_side[0] || (d4_quot < cutoff_q)) ? 16'd0 : d4_quot;
    clip_q    <= d4_side[1];
  end

  assign result_valid_o      = out_vld_q;
  assign reading_o           = reading_q;
  assign intensity_clipped_o = clip_q;

endmodule
